FILE: rtl/dmps_pkg.sv
// Shared types, constants and register codes of the dual motor speed sequencer.
`default_nettype none
package dmps_pkg;

	localparam int COUNT_BITS  = 10;
	localparam int DUTY_BITS   = 13;
	localparam int FRAC_BITS   = 12;
	localparam int GAIN_BITS   = 16;
	localparam int PERIOD_BITS = 8;
	localparam int SUM_BITS    = 16;

	localparam int ERR_BITS   = COUNT_BITS + 1;
	localparam int DIFF_BITS  = ERR_BITS + 1;
	localparam int POWER_BITS = DUTY_BITS + FRAC_BITS;
	localparam int PROD_BITS  = GAIN_BITS + 1 + ((SUM_BITS > DIFF_BITS) ? SUM_BITS : DIFF_BITS);
	localparam int CORR_BITS  = PROD_BITS + 2;
	localparam int V_BITS     = ((CORR_BITS > POWER_BITS + 1) ? CORR_BITS : POWER_BITS + 1) + 1;

	localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
	localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;
	localparam logic [DUTY_BITS-1:0]   START_DUTY = DUTY_BITS'(4000);
	localparam logic signed [SUM_BITS:0] SUM_POS  = (SUM_BITS+1)'((1 << (SUM_BITS - 1)) - 1);
	localparam logic signed [SUM_BITS:0] SUM_NEG  = -SUM_POS;

	// Sequencer modes.
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_WAIT = 2'd1;
	localparam logic [1:0] MODE_MOVE = 2'd2;
	localparam logic [1:0] MODE_STOP = 2'd3;

	// Configuration port.
	localparam int DATA_BITS    = 32;
	localparam int REG_IDX_BITS = 3;
	localparam int PADDR_BITS   = REG_IDX_BITS + 2;

	localparam logic [REG_IDX_BITS-1:0] REG_TARGET = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_GAIN_P = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_GAIN_I = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_GAIN_D = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_WAIT   = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_MOVE   = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_MIN    = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_MAX    = 3'd7;

	typedef struct packed {
		logic left_edge;
		logic right_edge;
		logic start_press;
		logic period_tick;
	} in_word_t;

	typedef struct packed {
		logic [1:0]           mode;
		logic [DUTY_BITS-1:0] left_duty;
		logic [DUTY_BITS-1:0] right_duty;
		logic                 drive_forward;
	} out_word_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0]  target_count;
		logic [GAIN_BITS-1:0]   gain_p;
		logic [GAIN_BITS-1:0]   gain_i;
		logic [GAIN_BITS-1:0]   gain_d;
		logic [PERIOD_BITS-1:0] wait_periods;
		logic [PERIOD_BITS-1:0] move_periods;
		logic [DUTY_BITS-1:0]   min_duty;
		logic [DUTY_BITS-1:0]   max_duty;
	} cfg_t;

	typedef struct packed {
		logic [POWER_BITS-1:0]      power;
		logic signed [ERR_BITS-1:0] prev;
		logic signed [SUM_BITS-1:0] sum;
	} pid_state_t;

endpackage
`default_nettype wire

FILE: rtl/dmps_cfg.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module dmps_cfg import dmps_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [DATA_BITS-1:0]  pwdata,
	output logic [DATA_BITS-1:0]       prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t                    cfg_q;
	logic [REG_IDX_BITS-1:0] idx;
	logic                    wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_BITS-1:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_count <= COUNT_BITS'(12);
			cfg_q.gain_p       <= GAIN_BITS'(12288);
			cfg_q.gain_i       <= GAIN_BITS'(2048);
			cfg_q.gain_d       <= GAIN_BITS'(41);
			cfg_q.wait_periods <= PERIOD_BITS'(20);
			cfg_q.move_periods <= PERIOD_BITS'(60);
			cfg_q.min_duty     <= DUTY_BITS'(1000);
			cfg_q.max_duty     <= DUTY_BITS'(7999);
		end else if (wr_en) begin
			unique case (idx)
				REG_TARGET: cfg_q.target_count <= pwdata[COUNT_BITS-1:0];
				REG_GAIN_P: cfg_q.gain_p       <= pwdata[GAIN_BITS-1:0];
				REG_GAIN_I: cfg_q.gain_i       <= pwdata[GAIN_BITS-1:0];
				REG_GAIN_D: cfg_q.gain_d       <= pwdata[GAIN_BITS-1:0];
				REG_WAIT:   cfg_q.wait_periods <= pwdata[PERIOD_BITS-1:0];
				REG_MOVE:   cfg_q.move_periods <= pwdata[PERIOD_BITS-1:0];
				REG_MIN:    cfg_q.min_duty     <= pwdata[DUTY_BITS-1:0];
				REG_MAX:    cfg_q.max_duty     <= pwdata[DUTY_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TARGET: prdata = DATA_BITS'(cfg_q.target_count);
			REG_GAIN_P: prdata = DATA_BITS'(cfg_q.gain_p);
			REG_GAIN_I: prdata = DATA_BITS'(cfg_q.gain_i);
			REG_GAIN_D: prdata = DATA_BITS'(cfg_q.gain_d);
			REG_WAIT:   prdata = DATA_BITS'(cfg_q.wait_periods);
			REG_MOVE:   prdata = DATA_BITS'(cfg_q.move_periods);
			REG_MIN:    prdata = DATA_BITS'(cfg_q.min_duty);
			REG_MAX:    prdata = DATA_BITS'(cfg_q.max_duty);
			default:    prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/dmps_pid.sv
// One PID update of a motor duty: error, clamped integral, derivative, duty clamp.
`default_nettype none
module dmps_pid import dmps_pkg::*; (
	input  wire cfg_t                   cfg,
	input  wire logic [COUNT_BITS-1:0]  count,
	input  wire pid_state_t             cur,
	output pid_state_t                  nxt
);

	logic signed [ERR_BITS-1:0]   err;
	logic signed [SUM_BITS:0]     sum_wide;
	logic signed [SUM_BITS-1:0]   sum_sat;
	logic signed [DIFF_BITS-1:0]  diff;
	logic signed [GAIN_BITS:0]    gp_s;
	logic signed [GAIN_BITS:0]    gi_s;
	logic signed [GAIN_BITS:0]    gd_s;
	logic signed [PROD_BITS-1:0]  p_prod;
	logic signed [PROD_BITS-1:0]  i_prod;
	logic signed [PROD_BITS-1:0]  d_prod;
	logic signed [CORR_BITS-1:0]  corr;
	logic signed [V_BITS-1:0]     pow_s;
	logic signed [V_BITS-1:0]     v;
	logic signed [V_BITS-1:0]     lo;
	logic signed [V_BITS-1:0]     hi;
	logic signed [V_BITS-1:0]     v_clamp;

	always_comb begin
		err      = $signed({1'b0, cfg.target_count}) - $signed({1'b0, count});
		sum_wide = (SUM_BITS+1)'(cur.sum) + (SUM_BITS+1)'(err);
		if (sum_wide > SUM_POS) begin
			sum_sat = SUM_POS[SUM_BITS-1:0];
		end else if (sum_wide < SUM_NEG) begin
			sum_sat = SUM_NEG[SUM_BITS-1:0];
		end else begin
			sum_sat = sum_wide[SUM_BITS-1:0];
		end
		diff = DIFF_BITS'(err) - DIFF_BITS'(cur.prev);

		gp_s   = $signed({1'b0, cfg.gain_p});
		gi_s   = $signed({1'b0, cfg.gain_i});
		gd_s   = $signed({1'b0, cfg.gain_d});
		p_prod = PROD_BITS'(gp_s) * PROD_BITS'(err);
		i_prod = PROD_BITS'(gi_s) * PROD_BITS'(sum_sat);
		d_prod = PROD_BITS'(gd_s) * PROD_BITS'(diff);
		corr   = CORR_BITS'(p_prod) + CORR_BITS'(i_prod) + CORR_BITS'(d_prod);

		pow_s = $signed({{(V_BITS-POWER_BITS){1'b0}}, cur.power});
		v     = pow_s + V_BITS'(corr);
		lo    = $signed({{(V_BITS-POWER_BITS){1'b0}}, cfg.min_duty, {FRAC_BITS{1'b0}}});
		hi    = $signed({{(V_BITS-POWER_BITS){1'b0}}, cfg.max_duty, {FRAC_BITS{1'b0}}});
		// when the limits cross, a value below the lower bound takes it and any other value takes the upper bound
		if (v < lo) begin
			v_clamp = lo;
		end else if (v > hi) begin
			v_clamp = hi;
		end else begin
			v_clamp = v;
		end

		nxt.power = v_clamp[POWER_BITS-1:0];
		nxt.prev  = err;
		nxt.sum   = sum_sat;
	end

endmodule
`default_nettype wire

FILE: rtl/dmps_seq.sv
// Sequencer state, edge counters and per-word next-state logic.
`default_nettype none
module dmps_seq import dmps_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire in_word_t word,
	input  wire cfg_t     cfg,
	output out_word_t     result
);

	logic [1:0]             mode_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic [COUNT_BITS-1:0]  lcnt_q;
	logic [COUNT_BITS-1:0]  rcnt_q;
	pid_state_t             lpid_q;
	pid_state_t             rpid_q;

	logic [1:0]             mode_n;
	logic [PERIOD_BITS-1:0] period_n;
	logic [PERIOD_BITS-1:0] period_inc;
	logic [COUNT_BITS-1:0]  lcnt_inc;
	logic [COUNT_BITS-1:0]  rcnt_inc;
	logic [COUNT_BITS-1:0]  lcnt_n;
	logic [COUNT_BITS-1:0]  rcnt_n;
	pid_state_t             lpid_upd;
	pid_state_t             rpid_upd;
	pid_state_t             lpid_n;
	pid_state_t             rpid_n;
	pid_state_t             pid_start;
	logic                   moving;

	dmps_pid u_pid_left (
		.cfg   (cfg),
		.count (lcnt_inc),
		.cur   (lpid_q),
		.nxt   (lpid_upd)
	);

	dmps_pid u_pid_right (
		.cfg   (cfg),
		.count (rcnt_inc),
		.cur   (rpid_q),
		.nxt   (rpid_upd)
	);

	always_comb begin
		pid_start.power = {START_DUTY, {FRAC_BITS{1'b0}}};
		pid_start.prev  = '0;
		pid_start.sum   = '0;

		// hold edge counters at full scale
		lcnt_inc   = (word.left_edge && lcnt_q != COUNT_MAX) ? lcnt_q + 1'b1 : lcnt_q;
		rcnt_inc   = (word.right_edge && rcnt_q != COUNT_MAX) ? rcnt_q + 1'b1 : rcnt_q;
		period_inc = (period_q != PERIOD_MAX) ? period_q + 1'b1 : period_q;

		mode_n   = mode_q;
		period_n = period_q;
		lcnt_n   = lcnt_inc;
		rcnt_n   = rcnt_inc;
		lpid_n   = lpid_q;
		rpid_n   = rpid_q;

		if (word.period_tick) begin
			lcnt_n = '0;
			rcnt_n = '0;
			unique case (mode_q)
				MODE_WAIT: begin
					if (period_inc >= cfg.wait_periods) begin
						mode_n   = MODE_MOVE;
						period_n = '0;
						lpid_n   = pid_start;
						rpid_n   = pid_start;
					end else begin
						period_n = period_inc;
					end
				end
				MODE_MOVE: begin
					period_n = period_inc;
					if (period_inc >= cfg.move_periods) begin
						mode_n = MODE_STOP;
					end else begin
						lpid_n = lpid_upd;
						rpid_n = rpid_upd;
					end
				end
				default: ;
			endcase
		end

		if (word.start_press && mode_n == MODE_IDLE) begin
			mode_n   = MODE_WAIT;
			period_n = '0;
		end

		moving               = (mode_n == MODE_MOVE);
		result.mode          = mode_n;
		result.left_duty     = moving ? lpid_n.power[POWER_BITS-1:FRAC_BITS] : '0;
		result.right_duty    = moving ? rpid_n.power[POWER_BITS-1:FRAC_BITS] : '0;
		result.drive_forward = moving;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			period_q <= '0;
			lcnt_q   <= '0;
			rcnt_q   <= '0;
			lpid_q   <= '0;
			rpid_q   <= '0;
		end else if (step) begin
			mode_q   <= mode_n;
			period_q <= period_n;
			lcnt_q   <= lcnt_n;
			rcnt_q   <= rcnt_n;
			lpid_q   <= lpid_n;
			rpid_q   <= rpid_n;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/dual_motor_pid_speed_sequencer.sv
// Top level: input register, sequencer with two PID units, result register.
//
// Input channel in_valid/in_stall/in_data carries one word of event flags:
// left and right encoder edges, start press and control period tick. The
// output channel out_valid/out_stall/out_data returns one word per input
// word: mode, both duty compare values and the drive direction.
// A word accepted into the input register is processed as it moves on
// into the result register, which a stall on the output can hold back,
// and the result is then offered on the output. One word per cycle is
// sustained while the receiver does not stall; the whole update,
// including the three gain multiplies per motor, fits between the input
// register and the result register. Configuration goes through the
// APB-style port (registers at 4*index, pready always high); the user must
// write it only while the block is idle, which the block does not enforce.
// Reset loads the register defaults, puts the sequencer in idle with all
// counters, duties and PID state cleared, and empties both registers.
// When the receiver stalls, the result word holds; the input register
// then holds too, and in_stall rises once it is occupied.
`default_nettype none
module dual_motor_pid_speed_sequencer import dmps_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_word_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_word_t                  out_data,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [DATA_BITS-1:0]  pwdata,
	output logic [DATA_BITS-1:0]       prdata,
	output logic                       pready
);

	cfg_t      cfg;
	in_word_t  word_s1;
	logic      valid_s1;
	out_word_t out_data_q;
	logic      out_valid_q;
	out_word_t result;
	logic      advance;
	logic      in_take;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	dmps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dmps_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.word   (word_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

endmodule
`default_nettype wire

FILE: bench/dual_motor_pid_speed_sequencer_tb.sv
// Self-checking bench for the dual motor PID speed sequencer: directed table, then random words.
`timescale 1ns / 1ps
module dual_motor_pid_speed_sequencer_tb;
	import dmps_pkg::*;

	localparam cfg_t RESET_CFG = '{target_count: 10'd12, gain_p: 16'd12288, gain_i: 16'd2048,
		gain_d: 16'd41, wait_periods: 8'd20, move_periods: 8'd60, min_duty: 13'd1000,
		max_duty: 13'd7999};

	localparam out_word_t OUT_IDLE = '{MODE_IDLE, '0, '0, 1'b0};
	localparam out_word_t OUT_WAIT = '{MODE_WAIT, '0, '0, 1'b0};
	localparam out_word_t OUT_ENTRY = '{MODE_MOVE, START_DUTY, START_DUTY, 1'b1};

	typedef struct packed {
		in_word_t  w;
		bit        typed;
		out_word_t want;
	} dir_row_t;

	// Flags read left, right, start, tick from the MSB. Expects wait_periods at zero.
	localparam dir_row_t DIR_ROWS [15] = '{
		'{4'b0000, 1'b1, OUT_IDLE},
		'{4'b1100, 1'b1, OUT_IDLE},
		'{4'b0001, 1'b1, OUT_IDLE},
		'{4'b1111, 1'b1, OUT_WAIT},
		'{4'b0010, 1'b1, OUT_WAIT},
		'{4'b1100, 1'b1, OUT_WAIT},
		'{4'b0001, 1'b1, OUT_ENTRY},
		'{4'b0001, 1'b0, OUT_IDLE},
		'{4'b1000, 1'b0, OUT_IDLE},
		'{4'b0100, 1'b0, OUT_IDLE},
		'{4'b1100, 1'b0, OUT_IDLE},
		'{4'b0011, 1'b0, OUT_IDLE},
		'{4'b1101, 1'b0, OUT_IDLE},
		'{4'b0000, 1'b0, OUT_IDLE},
		'{4'b1111, 1'b0, OUT_IDLE}
	};

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_word_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_word_t             out_data;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0]  pwdata = '0;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;

	dual_motor_pid_speed_sequencer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Predicted sequencer state, index 0 is the left motor.
	cfg_t       cfg_now = RESET_CFG;
	logic [1:0] mode_now = MODE_IDLE;
	int         ticks_in_mode = 0;
	int         edge_cnt [2] = '{0, 0};
	longint     power_q12 [2] = '{0, 0};
	int         prev_err [2] = '{0, 0};
	int         err_sum [2] = '{0, 0};

	out_word_t status_due [$];
	out_word_t due_w;
	int        fail_count = 0;
	int        send_gap_pct = 0;
	int        recv_stall_pct = 0;
	bit        hold_req = 1'b0;
	int        hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic void motor_pid_tick(int m);
		int     err;
		int     s;
		longint corr;
		longint v;
		longint lo;
		longint hi;
		err = int'(cfg_now.target_count) - edge_cnt[m];
		s = err_sum[m] + err;
		if (s > int'(SUM_POS)) s = int'(SUM_POS);
		if (s < int'(SUM_NEG)) s = int'(SUM_NEG);
		err_sum[m] = s;
		corr = longint'(cfg_now.gain_p) * err + longint'(cfg_now.gain_i) * s
			+ longint'(cfg_now.gain_d) * (err - prev_err[m]);
		prev_err[m] = err;
		v = power_q12[m] + corr;
		lo = longint'(cfg_now.min_duty) << FRAC_BITS;
		hi = longint'(cfg_now.max_duty) << FRAC_BITS;
		// when min sits above max, a value below min takes min and any other value takes max
		if (v < lo) v = lo;
		else if (v > hi) v = hi;
		power_q12[m] = v;
	endfunction

	function automatic out_word_t motor_status_after(in_word_t w);
		out_word_t r;
		if (w.left_edge && edge_cnt[0] < COUNT_MAX) edge_cnt[0]++;
		if (w.right_edge && edge_cnt[1] < COUNT_MAX) edge_cnt[1]++;
		if (w.period_tick) begin
			if ((mode_now == MODE_WAIT || mode_now == MODE_MOVE) && ticks_in_mode < PERIOD_MAX)
				ticks_in_mode++;
			if (mode_now == MODE_WAIT) begin
				if (ticks_in_mode >= cfg_now.wait_periods) begin
					mode_now = MODE_MOVE;
					ticks_in_mode = 0;
					for (int m = 0; m < 2; m++) begin
						power_q12[m] = longint'(START_DUTY) << FRAC_BITS;
						prev_err[m] = 0;
						err_sum[m] = 0;
					end
				end
			end else if (mode_now == MODE_MOVE) begin
				if (ticks_in_mode >= cfg_now.move_periods) begin
					mode_now = MODE_STOP;
				end else begin
					motor_pid_tick(0);
					motor_pid_tick(1);
				end
			end
			edge_cnt[0] = 0;
			edge_cnt[1] = 0;
		end
		if (w.start_press && mode_now == MODE_IDLE) begin
			mode_now = MODE_WAIT;
			ticks_in_mode = 0;
		end
		r.mode = mode_now;
		r.drive_forward = (mode_now == MODE_MOVE);
		r.left_duty = (mode_now == MODE_MOVE) ? DUTY_BITS'(power_q12[0] >>> FRAC_BITS) : '0;
		r.right_duty = (mode_now == MODE_MOVE) ? DUTY_BITS'(power_q12[1] >>> FRAC_BITS) : '0;
		return r;
	endfunction

	function automatic logic [DATA_BITS-1:0] reg_value(cfg_t c, logic [REG_IDX_BITS-1:0] idx);
		case (idx)
			REG_TARGET: return DATA_BITS'(c.target_count);
			REG_GAIN_P: return DATA_BITS'(c.gain_p);
			REG_GAIN_I: return DATA_BITS'(c.gain_i);
			REG_GAIN_D: return DATA_BITS'(c.gain_d);
			REG_WAIT:   return DATA_BITS'(c.wait_periods);
			REG_MOVE:   return DATA_BITS'(c.move_periods);
			REG_MIN:    return DATA_BITS'(c.min_duty);
			REG_MAX:    return DATA_BITS'(c.max_duty);
			default:    return '0;
		endcase
	endfunction

	function automatic in_word_t rand_flags(int pl, int pr, int ps, int pt);
		in_word_t w;
		w.left_edge = $urandom_range(99) < pl;
		w.right_edge = $urandom_range(99) < pr;
		w.start_press = $urandom_range(99) < ps;
		w.period_tick = $urandom_range(99) < pt;
		return w;
	endfunction

	// Called at a falling edge; leaves psel high so transfers can run back to back.
	task automatic reg_access(bit wr, logic [REG_IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] val,
			output logic [DATA_BITS-1:0] got);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
	endtask

	task automatic check_settings(cfg_t c);
		logic [DATA_BITS-1:0] got;
		for (int i = 0; i < (1 << REG_IDX_BITS); i++) begin
			reg_access(1'b0, REG_IDX_BITS'(i), '0, got);
			if (got !== reg_value(c, REG_IDX_BITS'(i))) begin
				fail_count++;
				if (fail_count <= 10)
					$display("register %0d reads %0d, expected %0d", i, got,
						reg_value(c, REG_IDX_BITS'(i)));
			end
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Drop valid and wait until every predicted word has come back.
	task automatic settle();
		in_valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_settings(cfg_t c);
		logic [DATA_BITS-1:0] got;
		settle();
		for (int i = 0; i < (1 << REG_IDX_BITS); i++)
			reg_access(1'b1, REG_IDX_BITS'(i), reg_value(c, REG_IDX_BITS'(i)), got);
		cfg_now = c;
		check_settings(c);
	endtask

	task automatic send_word(in_word_t w, bit typed, out_word_t typed_want);
		out_word_t p;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		p = motor_status_after(w);
		status_due.push_back(typed ? typed_want : p);
		@(negedge clk);
	endtask

	task automatic run_periods(int n, int lo, int hi, int pl, int pr);
		repeat (n) begin
			repeat ($urandom_range(hi, lo)) send_word(rand_flags(pl, pr, 2, 0), 1'b0, '0);
			send_word(rand_flags(pl, pr, 5, 100), 1'b0, '0);
		end
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = 60;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (status_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) $display("unexpected word %h", out_data);
			end else begin
				due_w = status_due.pop_front();
				if (due_w.mode !== out_data.mode || due_w.left_duty !== out_data.left_duty
						|| due_w.right_duty !== out_data.right_duty
						|| due_w.drive_forward !== out_data.drive_forward) begin
					fail_count++;
					if (fail_count <= 10)
						$display("exp/got mode %0d/%0d left %0d/%0d right %0d/%0d fwd %0b/%0b",
							due_w.mode, out_data.mode, due_w.left_duty, out_data.left_duty,
							due_w.right_duty, out_data.right_duty,
							due_w.drive_forward, out_data.drive_forward);
				end
			end
		end
	end

	initial begin
		cfg_t c;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_settings(RESET_CFG);

		send_gap_pct = 34;
		recv_stall_pct = 85;
		c = RESET_CFG;
		c.wait_periods = 8'd0;
		load_settings(c);
		foreach (DIR_ROWS[i]) send_word(DIR_ROWS[i].w, DIR_ROWS[i].typed, DIR_ROWS[i].want);

		// defaults with long limits so the move phase lasts
		c = RESET_CFG;
		c.wait_periods = 8'd255;
		c.move_periods = 8'd255;
		load_settings(c);
		run_periods(6, 8, 18, 80, 75);

		c.target_count = 10'($urandom_range(30, 5));
		c.gain_p = 16'($urandom_range(65535));
		c.gain_i = 16'($urandom_range(65535));
		c.gain_d = 16'($urandom_range(65535));
		c.min_duty = '0;
		c.max_duty = '1;
		load_settings(c);
		run_periods(3, 8, 30, 70, 70);
		// hold the output side so the pipe fills and stalls the input
		hold_req = 1'b1;
		run_periods(3, 8, 30, 70, 70);

		send_gap_pct = 85;
		recv_stall_pct = 34;
		c.target_count = 10'd20;
		c.gain_p = '1;
		c.gain_i = '1;
		c.gain_d = '1;
		c.min_duty = 13'd1000;
		c.max_duty = 13'd7999;
		load_settings(c);
		run_periods(5, 5, 20, 60, 80);

		c.gain_p = 16'($urandom_range(8191));
		c.gain_i = 16'($urandom_range(8191));
		c.gain_d = 16'($urandom_range(8191));
		c.min_duty = '1;
		c.max_duty = '0;
		load_settings(c);
		run_periods(5, 5, 20, 70, 60);

		c.target_count = 10'd15;
		c.gain_p = '0;
		c.gain_i = '0;
		c.gain_d = '0;
		c.wait_periods = 8'd1;
		c.min_duty = '0;
		c.max_duty = '1;
		load_settings(c);
		run_periods(4, 5, 20, 70, 70);

		send_gap_pct = 0;
		recv_stall_pct = 0;
		c.target_count = 10'($urandom_range(40));
		c.gain_p = 16'($urandom_range(20000));
		c.gain_i = 16'($urandom_range(20000));
		c.gain_d = 16'($urandom_range(20000));
		c.min_duty = 13'($urandom_range(4000));
		c.max_duty = 13'($urandom_range(8191, 4000));
		load_settings(c);
		run_periods(6, 5, 20, 75, 75);

		// zero target with busy encoders drives the error and its sum negative
		c.target_count = '0;
		c.gain_p = 16'd100;
		c.gain_i = 16'd50;
		c.gain_d = 16'd1000;
		c.min_duty = '0;
		c.max_duty = '1;
		load_settings(c);
		run_periods(3, 10, 20, 100, 90);

		// swing the error sum up to its positive limit
		c.target_count = '1;
		c.gain_p = 16'd4096;
		c.gain_i = 16'd1;
		c.gain_d = '0;
		load_settings(c);
		run_periods(40, 0, 2, 50, 50);

		// zero move limit stops on the next tick; stopped mode ignores everything after
		c.move_periods = 8'd0;
		load_settings(c);
		repeat (40) send_word(rand_flags(50, 50, 30, 30), 1'b0, '0);

		settle();
		if (fail_count == 0 && status_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/dmps_pkg.sv
rtl/dmps_cfg.sv
rtl/dmps_pid.sv
rtl/dmps_seq.sv
rtl/dual_motor_pid_speed_sequencer.sv
bench/dual_motor_pid_speed_sequencer_tb.sv
